// ===== hdl/vector3_math_unit_defines.svh =====
// Assertion macros for the vector math unit.
// Included by the top level; expects clk and rst_n in scope.
`ifndef VECTOR3_MATH_UNIT_DEFINES_SVH
`define VECTOR3_MATH_UNIT_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define VMU_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define VMU_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/vmu_pkg.sv =====
// Shared types, op codes and helpers for the vector math unit.
// No dependencies.
package vmu_pkg;

    localparam logic [2:0] OP_DOT   = 3'd0;
    localparam logic [2:0] OP_CROSS = 3'd1;
    localparam logic [2:0] OP_MAG   = 3'd2;
    localparam logic [2:0] OP_NORM  = 3'd3;
    localparam logic [2:0] OP_CLAMP = 3'd4;

    localparam int QDEPTH = 4;
    localparam int QPTR_W = 2;
    localparam int NSQ    = 32;  // root bits
    localparam int NDIV   = 31;  // quotient bits

    localparam logic signed [65:0] MAX66 = 66'sd2147483647;
    localparam logic signed [65:0] MIN66 = -66'sd2147483648;

    typedef enum logic [5:0] {
        K_NONE  = 6'b000001,
        K_DOT   = 6'b000010,
        K_CROSS = 6'b000100,
        K_MAG   = 6'b001000,
        K_NORM  = 6'b010000,
        K_CLAMP = 6'b100000
    } kind_t;

    typedef struct packed {
        logic        [2:0]  op;
        logic signed [31:0] ax;
        logic signed [31:0] ay;
        logic signed [31:0] az;
        logic signed [31:0] bx;
        logic signed [31:0] by;
        logic signed [31:0] bz;
        logic        [30:0] limit;
    } in_beat_t;

    typedef struct packed {
        logic signed [31:0] rx;
        logic signed [31:0] ry;
        logic signed [31:0] rz;
        logic signed [31:0] scalar;
        logic               saturated;
    } out_beat_t;

    typedef struct packed {
        kind_t              kind;
        logic signed [31:0] ax;
        logic signed [31:0] ay;
        logic signed [31:0] az;
        logic signed [31:0] bx;
        logic signed [31:0] by;
        logic signed [31:0] bz;
        logic        [30:0] limit;
    } item_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

    typedef struct packed {
        logic               flag;
        logic signed [31:0] val;
    } sat_t;

    // Result carried down the back pipeline.
    typedef struct packed {
        kind_t              kind;
        logic signed [31:0] rx;
        logic signed [31:0] ry;
        logic signed [31:0] rz;
        logic signed [31:0] sc;
        logic               sat;
        logic               do_div;
        logic        [30:0] k;
    } carry_t;

    typedef struct packed {
        logic [63:0] n;
        logic [33:0] rem;
        logic [31:0] root;
    } sqrt_t;

    typedef struct packed {
        logic [62:0] d;
        logic [31:0] rem;
        logic [30:0] q;
    } div_t;

    function automatic sat_t sat32(input logic signed [65:0] v);
        sat_t r;
        if (v > MAX66) begin
            r.flag = 1'b1;
            r.val  = 32'sh7FFFFFFF;
        end else if (v < MIN66) begin
            r.flag = 1'b1;
            r.val  = 32'sh80000000;
        end else begin
            r.flag = 1'b0;
            r.val  = v[31:0];
        end
        return r;
    endfunction

    function automatic logic [31:0] abs32(input logic signed [31:0] v);
        return v[31] ? 32'(-v) : 32'(v);
    endfunction

endpackage

// ===== hdl/vmu_front.sv =====
// Front: registers an incoming beat and classifies its op.
// Depends on vmu_pkg.
module vmu_front (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    output logic               req_stall,
    input  vmu_pkg::in_beat_t  req,
    input  vmu_pkg::q_status_t qs,
    output logic               item_valid,
    output vmu_pkg::item_t     item
);
    import vmu_pkg::*;

    logic  valid_reg;
    item_t item_reg;
    item_t item_next;
    logic  load;

    assign load      = !valid_reg || !qs.full;
    assign req_stall = !load;

    always_comb
    begin
        item_next.ax    = req.ax;
        item_next.ay    = req.ay;
        item_next.az    = req.az;
        item_next.bx    = req.bx;
        item_next.by    = req.by;
        item_next.bz    = req.bz;
        item_next.limit = req.limit;
        unique case (req.op)
            OP_DOT:   item_next.kind = K_DOT;
            OP_CROSS: item_next.kind = K_CROSS;
            OP_MAG:   item_next.kind = K_MAG;
            OP_NORM:  item_next.kind = K_NORM;
            OP_CLAMP: item_next.kind = K_CLAMP;
            default:  item_next.kind = K_NONE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (load)
        begin
            valid_reg <= req_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load && req_valid)
        begin
            item_reg <= item_next;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

// ===== hdl/vmu_queue.sv =====
// Short FIFO between front and back.
// Depends on vmu_pkg.
module vmu_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  vmu_pkg::item_t     in_item,
    input  logic               pop,
    output vmu_pkg::item_t     head,
    output vmu_pkg::q_status_t qs
);
    import vmu_pkg::*;

    item_t             mem_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W:0]   cnt_reg;
    logic              do_push;
    logic              do_pop;

    assign qs.full  = (cnt_reg == (QPTR_W + 1)'(QDEPTH));
    assign qs.empty = (cnt_reg == '0);
    assign do_push  = in_valid && !qs.full;
    assign do_pop   = pop && !qs.empty;
    assign head     = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= in_item;
        end
    end

endmodule

// ===== hdl/vmu_back.sv =====
// Back: products, pipelined square root, scaling and pipelined dividers.
// Depends on vmu_pkg.
module vmu_back #(
    parameter int FRAC_BITS = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  vmu_pkg::item_t     head,
    input  vmu_pkg::q_status_t qs,
    output logic               pop,
    output logic               rsp_valid,
    input  logic               rsp_stall,
    output vmu_pkg::out_beat_t rsp
);
    import vmu_pkg::*;

    localparam logic [30:0] NORM_ONE = 31'(1) << FRAC_BITS;

    logic en;
    logic rsp_valid_reg;
    out_beat_t rsp_reg;

    // whole back pipe moves together; output register is the skid point
    assign en  = !rsp_valid_reg || !rsp_stall;
    assign pop = en && !qs.empty;

    // ---------------- stage 1: operand select and products
    logic signed [31:0] opa [6];
    logic signed [31:0] opb [6];
    logic signed [63:0] prod [6];
    logic        [61:0] limsq;

    always_comb
    begin
        for (int i = 0; i < 6; i++)
        begin
            opa[i] = '0;
            opb[i] = '0;
        end
        unique case (head.kind)
            K_DOT:
            begin
                opa[0] = head.ax; opb[0] = head.bx;
                opa[1] = head.ay; opb[1] = head.by;
                opa[2] = head.az; opb[2] = head.bz;
            end
            K_CROSS:
            begin
                opa[0] = head.ay; opb[0] = head.bz;
                opa[1] = head.az; opb[1] = head.by;
                opa[2] = head.az; opb[2] = head.bx;
                opa[3] = head.ax; opb[3] = head.bz;
                opa[4] = head.ax; opb[4] = head.by;
                opa[5] = head.ay; opb[5] = head.bx;
            end
            default:
            begin
                opa[0] = head.ax; opb[0] = head.ax;
                opa[1] = head.ay; opb[1] = head.ay;
                opa[2] = head.az; opb[2] = head.az;
            end
        endcase
        for (int i = 0; i < 6; i++)
        begin
            prod[i] = opa[i] * opb[i];
        end
        limsq = head.limit * head.limit;
    end

    logic               v1_reg;
    kind_t              k1_reg;
    logic signed [31:0] ax1_reg, ay1_reg, az1_reg;
    logic        [30:0] lim1_reg;
    logic signed [63:0] p1_reg [6];
    logic        [61:0] lsq1_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= !qs.empty;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            k1_reg   <= head.kind;
            ax1_reg  <= head.ax;
            ay1_reg  <= head.ay;
            az1_reg  <= head.az;
            lim1_reg <= head.limit;
            lsq1_reg <= limsq;
            for (int i = 0; i < 6; i++)
            begin
                p1_reg[i] <= prod[i];
            end
        end
    end

    // ---------------- stage 2: sums, floor shift, saturation, classify
    logic signed [65:0] dot_sum;
    logic signed [65:0] cr_sh [3];
    sat_t               dot_s;
    sat_t               cr_s [3];
    logic        [63:0] sq;
    carry_t             c2;
    logic        [63:0] n2;

    always_comb
    begin
        dot_sum = (66'(p1_reg[0]) + 66'(p1_reg[1]) + 66'(p1_reg[2])) >>> FRAC_BITS;
        dot_s   = sat32(dot_sum);
        for (int i = 0; i < 3; i++)
        begin
            cr_sh[i] = (66'(p1_reg[2*i]) - 66'(p1_reg[2*i+1])) >>> FRAC_BITS;
            cr_s[i]  = sat32(cr_sh[i]);
        end
        sq = $unsigned(p1_reg[0]) + $unsigned(p1_reg[1]) + $unsigned(p1_reg[2]);

        c2.kind   = k1_reg;
        c2.rx     = '0;
        c2.ry     = '0;
        c2.rz     = '0;
        c2.sc     = '0;
        c2.sat    = 1'b0;
        c2.do_div = 1'b0;
        c2.k      = '0;
        n2        = '0;
        unique case (k1_reg)
            K_DOT:
            begin
                c2.sc  = dot_s.val;
                c2.sat = dot_s.flag;
            end
            K_CROSS:
            begin
                c2.rx  = cr_s[0].val;
                c2.ry  = cr_s[1].val;
                c2.rz  = cr_s[2].val;
                c2.sat = cr_s[0].flag | cr_s[1].flag | cr_s[2].flag;
            end
            K_MAG:
            begin
                n2 = sq;
            end
            K_NORM:
            begin
                // zero vector passes through as zero
                n2        = sq;
                c2.rx     = ax1_reg;
                c2.ry     = ay1_reg;
                c2.rz     = az1_reg;
                c2.do_div = (sq != '0);
                c2.k      = NORM_ONE;
            end
            K_CLAMP:
            begin
                n2        = sq;
                c2.rx     = ax1_reg;
                c2.ry     = ay1_reg;
                c2.rz     = az1_reg;
                c2.do_div = (sq > {2'b00, lsq1_reg});
                c2.k      = lim1_reg;
            end
            default:
            begin
                n2 = '0;
            end
        endcase
    end

    logic        v2_reg;
    carry_t      c2_reg;
    logic [63:0] n2_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v2_reg <= 1'b0;
        end
        else if (en)
        begin
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            c2_reg <= c2;
            n2_reg <= n2;
        end
    end

    // ---------------- square root, one root bit per stage
    logic   sv_reg [NSQ];
    carry_t sc_reg [NSQ];
    sqrt_t  ss_reg [NSQ];

    for (genvar j = 0; j < NSQ; j++)
    begin : g_sqrt
        sqrt_t       cur;
        sqrt_t       nxt;
        carry_t      cc;
        logic        cv;
        logic [35:0] t;
        logic [35:0] trial;

        if (j == 0)
        begin : g_first
            assign cur = {n2_reg, 34'd0, 32'd0};
            assign cc  = c2_reg;
            assign cv  = v2_reg;
        end
        else
        begin : g_next
            assign cur = ss_reg[j-1];
            assign cc  = sc_reg[j-1];
            assign cv  = sv_reg[j-1];
        end

        always_comb
        begin
            t     = {cur.rem, cur.n[63-2*j -: 2]};
            trial = {2'b00, cur.root, 2'b01};
            nxt.n = cur.n;
            if (t >= trial)
            begin
                nxt.rem  = 34'(t - trial);
                nxt.root = {cur.root[30:0], 1'b1};
            end
            else
            begin
                nxt.rem  = t[33:0];
                nxt.root = {cur.root[30:0], 1'b0};
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                sv_reg[j] <= 1'b0;
            end
            else if (en)
            begin
                sv_reg[j] <= cv;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                ss_reg[j] <= nxt;
                sc_reg[j] <= cc;
            end
        end
    end

    // ---------------- scale stage: |a| * k, magnitude result
    logic [31:0] m;
    carry_t      cm;
    div_t        dm [3];
    logic signed [31:0] comp [3];

    assign m = ss_reg[NSQ-1].root;

    always_comb
    begin
        cm      = sc_reg[NSQ-1];
        comp[0] = cm.rx;
        comp[1] = cm.ry;
        comp[2] = cm.rz;
        if (cm.kind == K_MAG)
        begin
            cm.sat = m[31];
            cm.sc  = m[31] ? 32'sh7FFFFFFF : $signed(m);
        end
        for (int l = 0; l < 3; l++)
        begin
            dm[l].d   = abs32(comp[l]) * cm.k;
            dm[l].rem = dm[l].d[62:31];
            dm[l].q   = '0;
        end
    end

    logic        vm_reg;
    carry_t      cm_reg;
    div_t        dm_reg [3];
    logic [31:0] mm_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vm_reg <= 1'b0;
        end
        else if (en)
        begin
            vm_reg <= sv_reg[NSQ-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cm_reg <= cm;
            mm_reg <= m;
            for (int l = 0; l < 3; l++)
            begin
                dm_reg[l] <= dm[l];
            end
        end
    end

    // ---------------- three restoring dividers, one quotient bit per stage
    logic        dv_reg [NDIV];
    carry_t      dc_reg [NDIV];
    logic [31:0] dmm_reg [NDIV];
    div_t        dd_reg [NDIV][3];

    for (genvar i = 0; i < NDIV; i++)
    begin : g_div
        div_t        cur [3];
        div_t        nxt [3];
        carry_t      cc;
        logic        cv;
        logic [31:0] mc;
        logic [32:0] t [3];

        if (i == 0)
        begin : g_first
            assign cur[0] = dm_reg[0];
            assign cur[1] = dm_reg[1];
            assign cur[2] = dm_reg[2];
            assign cc     = cm_reg;
            assign cv     = vm_reg;
            assign mc     = mm_reg;
        end
        else
        begin : g_next
            assign cur[0] = dd_reg[i-1][0];
            assign cur[1] = dd_reg[i-1][1];
            assign cur[2] = dd_reg[i-1][2];
            assign cc     = dc_reg[i-1];
            assign cv     = dv_reg[i-1];
            assign mc     = dmm_reg[i-1];
        end

        always_comb
        begin
            for (int l = 0; l < 3; l++)
            begin
                t[l]     = {cur[l].rem, cur[l].d[NDIV-1-i]};
                nxt[l].d = cur[l].d;
                if (t[l] >= {1'b0, mc})
                begin
                    nxt[l].rem = 32'(t[l] - {1'b0, mc});
                    nxt[l].q   = {cur[l].q[29:0], 1'b1};
                end
                else
                begin
                    nxt[l].rem = t[l][31:0];
                    nxt[l].q   = {cur[l].q[29:0], 1'b0};
                end
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                dv_reg[i] <= 1'b0;
            end
            else if (en)
            begin
                dv_reg[i] <= cv;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                dc_reg[i]  <= cc;
                dmm_reg[i] <= mc;
                for (int l = 0; l < 3; l++)
                begin
                    dd_reg[i][l] <= nxt[l];
                end
            end
        end
    end

    // ---------------- final: sign the quotients, output register
    carry_t    cf;
    out_beat_t rsp_next;
    logic signed [31:0] fin [3];
    logic signed [31:0] qv;

    always_comb
    begin
        cf      = dc_reg[NDIV-1];
        fin[0]  = cf.rx;
        fin[1]  = cf.ry;
        fin[2]  = cf.rz;
        qv      = '0;
        if (cf.do_div)
        begin
            // quotient is bounded by k, so it always fits
            for (int l = 0; l < 3; l++)
            begin
                qv     = $signed({1'b0, dd_reg[NDIV-1][l].q});
                fin[l] = fin[l][31] ? -qv : qv;
            end
        end
        rsp_next.rx        = fin[0];
        rsp_next.ry        = fin[1];
        rsp_next.rz        = fin[2];
        rsp_next.scalar    = cf.sc;
        rsp_next.saturated = cf.sat;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            rsp_valid_reg <= dv_reg[NDIV-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

// ===== hdl/vector3_math_unit.sv =====
// Top level of the 3D vector math unit (dot, cross, magnitude, normalize,
// clamp magnitude in signed fixed point). Depends on vmu_pkg, vmu_front,
// vmu_queue, vmu_back and vector3_math_unit_defines.svh.
//
//  channel | handshake          | beat
//  --------+--------------------+----------------------------------------
//  req     | req_valid/req_stall| op, ax..az, bx..bz, limit (in_beat_t)
//  rsp     | rsp_valid/rsp_stall| rx, ry, rz, scalar, saturated
//
// One beat per cycle while the response is not stalled; an accepted beat
// passes through the front register (loaded at acceptance), the queue,
// two product/sum stages, 32 square-root stages, a scale stage, 31 divider
// stages and the output register.
// Reset clears only valid bits, queue pointers and the queue count.
// A stalled response freezes the back pipe; the front keeps taking beats
// until the 4-entry queue fills, then asserts req_stall.
module vector3_math_unit #(
    parameter int FRAC_BITS = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    output logic               req_stall,
    input  vmu_pkg::in_beat_t  req,
    output logic               rsp_valid,
    input  logic               rsp_stall,
    output vmu_pkg::out_beat_t rsp
);
    import vmu_pkg::*;

    `include "vector3_math_unit_defines.svh"

    logic      fr_valid;
    item_t     fr_item;
    item_t     head;
    q_status_t qs;
    logic      pop;

    // front: register and decode the op
    vmu_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req_valid),
        .req_stall  (req_stall),
        .req        (req),
        .qs         (qs),
        .item_valid (fr_valid),
        .item       (fr_item)
    );

    // decoupling queue
    vmu_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (fr_valid),
        .in_item  (fr_item),
        .pop      (pop),
        .head     (head),
        .qs       (qs)
    );

    // back: arithmetic pipeline with output register
    vmu_back #(
        .FRAC_BITS (FRAC_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (head),
        .qs        (qs),
        .pop       (pop),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    `VMU_ASSERT_NOW(a_no_front_overwrite, req_valid && !req_stall, !fr_valid || !qs.full, "front overwritten while queue full")
    `VMU_ASSERT_NOW(a_queue_flags, fr_valid || !fr_valid, !(qs.full && qs.empty), "queue both full and empty")
    `VMU_ASSERT_NOW(a_pop_only_moving, pop, !rsp_valid || !rsp_stall, "queue popped while back pipe frozen")

endmodule

// ===== tb/tb_top.sv =====
// Self-checking testbench for vector3_math_unit: directed table, then random beats.
// Expected results: in-bench predictor or hand-written rows. Depends on vmu_pkg and the RTL.
`timescale 1ns / 1ps

module tb_top;
    import vmu_pkg::*;

    localparam int FRAC       = 16;
    localparam int N_RANDOM   = 500;
    localparam int N_CALM     = 100;   // tail of the run with no idling
    localparam int IDLE_LIMIT = 5000;  // cycles without any beat moving
    localparam int LONG_HOLD  = 300;   // long receiver hold-off

    logic      clk;
    logic      rst_n;
    logic      req_valid;
    logic      req_stall;
    in_beat_t  req;
    logic      rsp_valid;
    logic      rsp_stall;
    out_beat_t rsp;

    vector3_math_unit u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    initial clk = 1'b0;
    always #2 clk = ~clk;

    // Results still owed by the block, oldest first.
    out_beat_t results_due[$];
    int        mismatches = 0;
    int        beats_sent = 0;
    bit        calm       = 1'b0;  // no idling on either side
    bit        sent_all   = 1'b0;
    bit        long_held  = 1'b0;

    // ---------------------------------------------------------------
    // Predictor
    // ---------------------------------------------------------------

    // Clip to signed 32 bits, raising the flag on a clip.
    function automatic logic signed [31:0] clip32(input logic signed [69:0] v, inout bit flag);
        if (v > 70'sd2147483647) begin
            flag = 1'b1;
            return 32'sh7FFFFFFF;
        end
        if (v < -70'sd2147483648) begin
            flag = 1'b1;
            return 32'sh80000000;
        end
        return v[31:0];
    endfunction

    // floor(sqrt(n)), bit by bit from the top; the root fits in 33 bits.
    function automatic logic [69:0] root_floor(input logic [69:0] n);
        logic [69:0] r;
        logic [69:0] trial;
        r = '0;
        for (int k = 33; k >= 0; k--) begin
            trial = r | (70'd1 << k);
            if (trial * trial <= n)
                r = trial;
        end
        return r;
    endfunction

    // sign(a) * trunc(|a| * k / m), quotient capped at 2^31 before the clip.
    function automatic logic signed [31:0] rescale(input logic signed [31:0] a,
                                                   input logic [69:0] k,
                                                   input logic [69:0] m,
                                                   inout bit flag);
        logic [69:0]        mag;
        logic [69:0]        q;
        logic signed [69:0] s;
        mag = a[31] ? 70'(-70'(a)) : 70'(a);
        q   = (mag * k) / m;
        if (q > 70'h8000_0000)
            q = 70'h8000_0000;
        s = a[31] ? -$signed(q) : $signed(q);
        return clip32(s, flag);
    endfunction

    function automatic out_beat_t vec_math_expected(input in_beat_t b);
        out_beat_t          r;
        bit                 flag;
        logic signed [69:0] ax, ay, az, bx, by, bz;
        logic [69:0]        sq, m, lim;
        logic signed [69:0] acc;
        ax = b.ax; ay = b.ay; az = b.az;
        bx = b.bx; by = b.by; bz = b.bz;
        lim  = 70'(b.limit);
        flag = 1'b0;
        r    = '0;
        sq   = 70'(ax * ax + ay * ay + az * az);
        m    = root_floor(sq);
        case (b.op)
            OP_DOT: begin
                acc = (ax * bx + ay * by + az * bz) >>> FRAC;
                r.scalar = clip32(acc, flag);
            end
            OP_CROSS: begin
                r.rx = clip32((ay * bz - az * by) >>> FRAC, flag);
                r.ry = clip32((az * bx - ax * bz) >>> FRAC, flag);
                r.rz = clip32((ax * by - ay * bx) >>> FRAC, flag);
            end
            OP_MAG:
                r.scalar = clip32($signed(m), flag);
            OP_NORM: begin
                // zero vector stays zero
                if (m != 0) begin
                    r.rx = rescale(b.ax, 70'd1 << FRAC, m, flag);
                    r.ry = rescale(b.ay, 70'd1 << FRAC, m, flag);
                    r.rz = rescale(b.az, 70'd1 << FRAC, m, flag);
                end
            end
            OP_CLAMP: begin
                if (sq > lim * lim && m != 0) begin
                    r.rx = rescale(b.ax, lim, m, flag);
                    r.ry = rescale(b.ay, lim, m, flag);
                    r.rz = rescale(b.az, lim, m, flag);
                end else begin
                    r.rx = b.ax;
                    r.ry = b.ay;
                    r.rz = b.az;
                end
            end
            default: ;  // unknown op: all zero
        endcase
        r.saturated = flag;
        return r;
    endfunction

    // ---------------------------------------------------------------
    // Sender
    // ---------------------------------------------------------------

    // Offer one beat and hold it until taken; record what it must produce.
    task automatic send_beat(input in_beat_t b, input bit typed, input out_beat_t want);
        req       <= b;
        req_valid <= 1'b1;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
        results_due.push_back(typed ? want : vec_math_expected(b));
        beats_sent++;
    endtask

    // Random idle gap before some beats.
    task automatic maybe_gap();
        if (!calm && $urandom_range(0, 3) == 0) begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clk);
        end
    endtask

    // Component mix: full range, small values, mid-range values and range corners.
    function automatic logic [31:0] rand_comp();
        case ($urandom_range(0, 4))
            0, 1: return $urandom;
            2: return 32'($signed($urandom_range(0, 8 << FRAC)) - (4 << FRAC));
            3: case ($urandom_range(0, 4))
                   0: return 32'h8000_0000;
                   1: return 32'h7FFF_FFFF;
                   2: return 32'h0;
                   3: return 32'h1;
                   default: return 32'hFFFF_FFFF;
               endcase
            default: return 32'($signed($urandom_range(0, 32'h00FF_FFFF)) - 32'sh0080_0000);
        endcase
    endfunction

    function automatic in_beat_t rand_beat();
        in_beat_t b;
        // mostly defined ops, a few unknown codes
        b.op = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(5, 7)) : 3'($urandom_range(0, 4));
        b.ax = rand_comp();
        b.ay = rand_comp();
        b.az = rand_comp();
        b.bx = rand_comp();
        b.by = rand_comp();
        b.bz = rand_comp();
        case ($urandom_range(0, 3))
            0: b.limit = 31'($urandom);
            1: b.limit = 31'($urandom_range(0, 16 << FRAC));
            2: b.limit = $urandom_range(0, 1) ? 31'h7FFF_FFFF : 31'h0;
            default: b.limit = 31'($urandom_range(0, 32'h00FF_FFFF));
        endcase
        return b;
    endfunction

    // Directed table: stimulus plus an optional hand-written result.
    in_beat_t  tbl_in[$];
    bit        tbl_typed[$];
    out_beat_t tbl_want[$];

    task automatic add_row(input logic [2:0] op,
                           input logic [31:0] ax, ay, az, bx, by, bz,
                           input logic [30:0] limit,
                           input bit typed = 1'b0,
                           input out_beat_t want = '0);
        in_beat_t b;
        b.op = op; b.ax = ax; b.ay = ay; b.az = az;
        b.bx = bx; b.by = by; b.bz = bz; b.limit = limit;
        tbl_in.push_back(b);
        tbl_typed.push_back(typed);
        tbl_want.push_back(want);
    endtask

    localparam logic [31:0] MINV = 32'h8000_0000;
    localparam logic [31:0] MAXV = 32'h7FFF_FFFF;
    localparam logic [31:0] ONE  = 32'h0001_0000;

    initial begin
        out_beat_t w;
        rst_n     = 1'b0;
        req_valid = 1'b0;
        req       = '0;

        // -- results known at a glance --
        w = '0; w.scalar = MAXV; w.saturated = 1'b1;
        add_row(OP_MAG, MINV, MINV, MINV, 0, 0, 0, 0, 1'b1, w);      // magnitude clips
        add_row(OP_DOT, MINV, MINV, MINV, MINV, MINV, MINV, 0, 1'b1, w); // dot clips high
        w = '0; w.scalar = MINV; w.saturated = 1'b1;
        add_row(OP_DOT, MINV, MINV, MINV, MAXV, MAXV, MAXV, 0, 1'b1, w); // dot clips low
        w = '0;
        add_row(OP_NORM, 0, 0, 0, MAXV, MAXV, MAXV, MAXV, 1'b1, w);  // zero vector normalize
        add_row(3'd5, MAXV, ONE, MINV, ONE, MAXV, MINV, MAXV, 1'b1, w); // unknown ops
        add_row(3'd6, ONE, ONE, ONE, ONE, ONE, ONE, 31'd5, 1'b1, w);
        add_row(3'd7, MINV, MINV, MINV, MINV, MINV, MINV, 0, 1'b1, w);
        add_row(OP_CLAMP, 0, 0, 0, 0, 0, 0, 0, 1'b1, w);             // zero vector, zero limit
        w.rx = ONE; w.ry = 2 * ONE; w.rz = 3 * ONE;
        add_row(OP_CLAMP, ONE, 2 * ONE, 3 * ONE, 0, 0, 0, 31'h7FFF_FFFF, 1'b1, w); // no clamp

        // -- predictor-checked rows --
        add_row(OP_DOT, ONE, 2 * ONE, 3 * ONE, 4 * ONE, -5 * ONE, 6 * ONE, 0);
        add_row(OP_DOT, 32'hFFFF_FFFF, 1, 0, 1, 1, 0, 0);            // products cancel to zero
        add_row(OP_CROSS, ONE, 0, 0, 0, ONE, 0, 0);
        add_row(OP_CROSS, MINV, MAXV, MINV, MAXV, MINV, MAXV, 0);
        add_row(OP_CROSS, MINV, MINV, MINV, MAXV, MINV, MAXV, 0);
        add_row(OP_MAG, 3 * ONE, 4 * ONE, 0, 0, 0, 0, 0);
        add_row(OP_MAG, 1, 1, 1, 0, 0, 0, 0);
        add_row(OP_NORM, MINV, MINV, MINV, 0, 0, 0, 0);
        add_row(OP_NORM, MAXV, 0, 0, 0, 0, 0, 0);
        add_row(OP_NORM, 3 * ONE, -4 * ONE, 1, 0, 0, 0, 0);
        add_row(OP_CLAMP, 10 * ONE, 0, 0, 0, 0, 0, 31'(2 * ONE));    // clamp applies
        add_row(OP_CLAMP, 5 * ONE, 0, 0, 0, 0, 0, 31'(5 * ONE));     // exactly at limit
        add_row(OP_CLAMP, ONE, ONE, ONE, 0, 0, 0, 0);                // zero limit
        add_row(OP_CLAMP, MINV, MINV, MINV, 0, 0, 0, 31'h7FFF_FFFF);
        add_row(OP_CLAMP, MINV, MAXV, 1, 0, 0, 0, 31'h4000_0000);

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (tbl_in[i]) begin
            maybe_gap();
            send_beat(tbl_in[i], tbl_typed[i], tbl_want[i]);
        end

        for (int i = 0; i < N_RANDOM; i++) begin
            if (i == N_RANDOM - N_CALM)
                calm = 1'b1;
            maybe_gap();
            send_beat(rand_beat(), 1'b0, '0);
        end
        req_valid <= 1'b0;
        sent_all = 1'b1;
    end

    // ---------------------------------------------------------------
    // Receiver: short stall bursts, and one long hold-off once the run
    // is under way so the internal queue fills and req_stall rises.
    // ---------------------------------------------------------------
    initial begin
        rsp_stall = 1'b0;
        @(posedge rst_n);
        forever begin
            if (!calm && !long_held && beats_sent >= 150) begin
                rsp_stall <= 1'b1;
                repeat (LONG_HOLD) @(posedge clk);
                long_held = 1'b1;
            end else if (!calm && $urandom_range(0, 3) == 0) begin
                rsp_stall <= 1'b1;
                repeat ($urandom_range(1, 5)) @(posedge clk);
            end else begin
                rsp_stall <= 1'b0;
                @(posedge clk);
            end
        end
    end

    // ---------------------------------------------------------------
    // Checker: each response beat against the oldest expectation.
    // ---------------------------------------------------------------
    always @(posedge clk) begin
        out_beat_t want;
        if (rst_n && rsp_valid && !rsp_stall) begin
            if (results_due.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: unexpected response beat %h", rsp);
            end else begin
                want = results_due.pop_front();
                if (rsp.rx !== want.rx || rsp.ry !== want.ry || rsp.rz !== want.rz ||
                    rsp.scalar !== want.scalar || rsp.saturated !== want.saturated) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("ERROR: rx/ry/rz/scalar/sat exp %h %h %h %h %b got %h %h %h %h %b",
                                 want.rx, want.ry, want.rz, want.scalar, want.saturated,
                                 rsp.rx, rsp.ry, rsp.rz, rsp.scalar, rsp.saturated);
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // Watchdog: cycles in which no beat moves on either channel.
    // ---------------------------------------------------------------
    int quiet_cycles = 0;
    always @(posedge clk) begin
        if (rst_n) begin
            if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= IDLE_LIMIT) begin
                $display("ERROR: no progress for %0d cycles", IDLE_LIMIT);
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    // End of run: drain, then let the pipe settle for stray beats.
    initial begin
        wait (sent_all);
        while (results_due.size() != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);
        if (mismatches == 0 && results_due.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
